FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the slice binner RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define TSB_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TSB_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tsb_pkg.sv
// ---------------------------------------------------------------------------
// tsb_pkg
// Types and constants shared by the time slice event binner modules.
// ---------------------------------------------------------------------------
package tsb_pkg;

    localparam int TIME_BITS     = 52;
    localparam int LEN_BITS      = 40;
    localparam int CLS_BITS      = 2;
    localparam int AMT_BITS      = 16;
    localparam int IDX_BITS      = 32;
    localparam int OUT_SUM_BITS  = 32;
    localparam int MARK_BITS     = 3;
    localparam int KIND_BITS     = 2;
    localparam int NUM_CLASSES   = 4;
    localparam int IN_DATA_BITS  = 72;   // 52 + 2 + 16, padded to bytes
    localparam int OUT_DATA_BITS = 216;  // 32 + 52 + 4*32 + 3, padded to bytes

    // remainder unit: one timestamp bit per step
    localparam int DIV_STEPS = TIME_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

    // one minute in microseconds
    localparam logic [LEN_BITS-1:0] LEN_RESET = 40'd60000000;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    localparam logic [CLS_BITS-1:0] CLS_NORMAL  = 2'd0;
    localparam logic [CLS_BITS-1:0] CLS_ERROR   = 2'd1;
    localparam logic [CLS_BITS-1:0] CLS_WARNING = 2'd2;
    localparam logic [CLS_BITS-1:0] CLS_MARK    = 2'd3;

    typedef enum logic [KIND_BITS-1:0] {
        ROW_CLOSED = 2'd0,
        ROW_GAP    = 2'd1,
        ROW_FLUSH  = 2'd2,
        ROW_REJECT = 2'd3
    } row_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUB,
        ST_DIFF,
        ST_GAP,
        ST_EMIT_A,
        ST_EMIT_B,
        ST_UPDATE
    } tsb_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } tsb_div_status_t;

    typedef struct packed {
        logic add;
        logic clear;
    } tsb_sum_ctrl_t;

endpackage

FILE: hdl/tsb_rem_unit.sv
// ---------------------------------------------------------------------------
// tsb_rem_unit
// Bit-serial remainder: shifts the timestamp in MSB first, one trial
// subtract of the slice length per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tsb_rem_unit
    import tsb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [TIME_BITS-1:0] dividend,
    input  logic [LEN_BITS-1:0]  divisor,
    output tsb_div_status_t      status,
    output logic [LEN_BITS-1:0]  rem
);

    logic [TIME_BITS-1:0] shift_reg;
    logic [LEN_BITS-1:0]  rem_reg, rem_next;
    logic [LEN_BITS-1:0]  div_reg;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [LEN_BITS:0]    partial;
    logic [LEN_BITS+1:0]  trial;

    // partial remainder stays below 2*divisor, so one compare/subtract per bit
    always_comb
    begin
        partial = {rem_reg, shift_reg[TIME_BITS-1]};
        trial   = {1'b0, partial} - {2'b00, div_reg};
        if (!trial[LEN_BITS+1])
            rem_next = trial[LEN_BITS-1:0];
        else
            rem_next = partial[LEN_BITS-1:0];
    end

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
            cnt_next = CNT_BITS'(DIV_STEPS);
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_BITS'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            shift_reg <= {shift_reg[TIME_BITS-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;
    assign rem         = rem_reg;

    `TSB_ASSERT_IMP(a_rem_below_len, clk, rst_n, done_reg, rem_reg < div_reg, "remainder not reduced")
    `TSB_ASSERT_NXT(a_done_pulse, clk, rst_n, done_reg, !done_reg, "done held longer than one cycle")

endmodule

FILE: hdl/tsb_sum_bank.sv
// ---------------------------------------------------------------------------
// tsb_sum_bank
// Per-class saturating sums of the open row, with nonzero flags.
// ---------------------------------------------------------------------------
module tsb_sum_bank
    import tsb_pkg::*;
#(
    parameter int SUM_BITS = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tsb_sum_ctrl_t                         ctrl,
    input  logic [CLS_BITS-1:0]                   cls,
    input  logic [AMT_BITS-1:0]                   amt,
    output logic [NUM_CLASSES-1:0][SUM_BITS-1:0]  sums,
    output logic [MARK_BITS-1:0]                  mark_bits
);

    logic [NUM_CLASSES-1:0][SUM_BITS-1:0] sums_reg, sums_next;
    logic [SUM_BITS-1:0]                  base;
    logic [SUM_BITS:0]                    total;

    // clear and add in one step opens a new row holding this event
    always_comb
    begin
        sums_next = sums_reg;
        base      = ctrl.clear ? '0 : sums_reg[cls];
        total     = {1'b0, base} + {{(SUM_BITS + 1 - AMT_BITS){1'b0}}, amt};
        if (ctrl.add)
        begin
            if (ctrl.clear)
                sums_next = '0;
            sums_next[cls] = total[SUM_BITS] ? '1 : total[SUM_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sums_reg <= '0;
        else
            sums_reg <= sums_next;
    end

    assign sums         = sums_reg;
    assign mark_bits[0] = (sums_reg[CLS_WARNING] != '0);
    assign mark_bits[1] = (sums_reg[CLS_ERROR] != '0);
    assign mark_bits[2] = (sums_reg[CLS_MARK] != '0);

endmodule

FILE: hdl/time_slice_event_binner_unit.sv
// ---------------------------------------------------------------------------
// time_slice_event_binner_unit
// An add event runs the 52-step remainder (ST_DIV), then ST_SUB, ST_DIFF
// and ST_GAP, then ST_EMIT_A and ST_EMIT_B as needed, then ST_UPDATE; a reject
// goes back to ST_IDLE from ST_EMIT_A, and a flush emits from ST_EMIT_A only.
// No new transfer is taken outside ST_IDLE; an output stall holds the EMIT states.
// Async reset clears row state and sums; slice_length returns to one minute.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module time_slice_event_binner_unit
    import tsb_pkg::*;
#(
    parameter int SUM_BITS = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [LEN_BITS-1:0]      cfg_wr_data,    // slice_length
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,        // event_time, event_class, amount
    input  logic                     s_tuser,        // cmd
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,        // row_index, row_time, sum_normal,
                                                     // sum_error, sum_warning, sum_mark,
                                                     // mark_bits
    output logic [KIND_BITS-1:0]     m_tuser,        // row_kind
    output logic                     m_tlast         // is_last
);

    tsb_state_t state_reg, state_next;

    logic [LEN_BITS-1:0]  slice_length_reg;
    logic                 have_row_reg;
    logic [TIME_BITS-1:0] cur_slice_reg;
    logic [IDX_BITS-1:0]  cur_index_reg;

    logic                 cmd_reg;
    logic [TIME_BITS-1:0] time_reg;
    logic [CLS_BITS-1:0]  cls_reg;
    logic [AMT_BITS-1:0]  amt_reg;
    logic [LEN_BITS-1:0]  len_reg;
    logic [TIME_BITS-1:0] slice_reg;
    logic [TIME_BITS-1:0] diff_reg;
    logic                 lt_reg;
    logic                 gt_reg;
    logic                 gap_reg;
    logic [TIME_BITS-1:0] gap_time_reg;

    logic                     m_tvalid_reg;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg;
    logic [KIND_BITS-1:0]     m_tuser_reg;
    logic                     m_tlast_reg;

    logic                 in_accept;
    logic                 out_free;
    logic [LEN_BITS-1:0]  eff_len;
    logic [TIME_BITS-1:0] len_ext;
    logic [TIME_BITS:0]   diff_full;

    // FSM outputs
    logic                 ready;
    logic                 div_start;
    logic                 out_load;
    row_kind_t            out_kind;
    logic                 out_last;
    tsb_sum_ctrl_t        sum_ctrl;

    tsb_div_status_t                      div_status;
    logic [LEN_BITS-1:0]                  rem;
    logic [NUM_CLASSES-1:0][SUM_BITS-1:0] sums;
    logic [MARK_BITS-1:0]                 sum_marks;

    logic [IDX_BITS-1:0]                      o_index;
    logic [TIME_BITS-1:0]                     o_time;
    logic [NUM_CLASSES-1:0][OUT_SUM_BITS-1:0] o_sums;
    logic [MARK_BITS-1:0]                     o_marks;
    logic [SUM_BITS+OUT_SUM_BITS-1:0]         sum_wide;

    assign in_accept = s_tvalid && ready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign eff_len   = (slice_length_reg == '0) ? LEN_BITS'(1) : slice_length_reg;
    assign len_ext   = {{(TIME_BITS - LEN_BITS){1'b0}}, len_reg};
    assign diff_full = {1'b0, slice_reg} - {1'b0, cur_slice_reg};

    tsb_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s_tdata[TIME_BITS-1:0]),
        .divisor  (eff_len),
        .status   (div_status),
        .rem      (rem)
    );

    tsb_sum_bank #(
        .SUM_BITS (SUM_BITS)
    ) u_sums (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (sum_ctrl),
        .cls       (cls_reg),
        .amt       (amt_reg),
        .sums      (sums),
        .mark_bits (sum_marks)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_FLUSH)
                        state_next = have_row_reg ? ST_EMIT_A : ST_IDLE;
                    else
                        state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                    state_next = ST_SUB;
            end
            ST_SUB:
                state_next = ST_DIFF;
            ST_DIFF:
                state_next = ST_GAP;
            ST_GAP:
            begin
                if (have_row_reg && (lt_reg || gt_reg))
                    state_next = ST_EMIT_A;
                else
                    state_next = ST_UPDATE;
            end
            ST_EMIT_A:
            begin
                if (out_free)
                begin
                    if (cmd_reg == CMD_FLUSH || lt_reg)
                        state_next = ST_IDLE;
                    else if (gap_reg)
                        state_next = ST_EMIT_B;
                    else
                        state_next = ST_UPDATE;
                end
            end
            ST_EMIT_B:
            begin
                if (out_free)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb
    begin
        ready          = 1'b0;
        div_start      = 1'b0;
        out_load       = 1'b0;
        out_kind       = ROW_CLOSED;
        out_last       = 1'b1;
        sum_ctrl.add   = 1'b0;
        sum_ctrl.clear = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                ready     = 1'b1;
                div_start = s_tvalid && (s_tuser == CMD_ADD);
            end
            ST_EMIT_A:
            begin
                out_load = out_free;
                if (cmd_reg == CMD_FLUSH)
                    out_kind = ROW_FLUSH;
                else if (lt_reg)
                    out_kind = ROW_REJECT;
                else
                begin
                    out_kind = ROW_CLOSED;
                    out_last = !gap_reg;
                end
            end
            ST_EMIT_B:
            begin
                out_load = out_free;
                out_kind = ROW_GAP;
            end
            ST_UPDATE:
            begin
                sum_ctrl.add   = 1'b1;
                sum_ctrl.clear = !have_row_reg || gt_reg;
            end
            default:
            begin
                ready = 1'b0;
            end
        endcase
    end

    // result fields; gap and reject rows carry zero sums
    always_comb
    begin
        o_index  = cur_index_reg;
        o_time   = cur_slice_reg;
        o_marks  = sum_marks;
        sum_wide = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            sum_wide  = {{OUT_SUM_BITS{1'b0}}, sums[c]};
            o_sums[c] = sum_wide[OUT_SUM_BITS-1:0];
        end
        case (out_kind)
            ROW_GAP:
            begin
                o_index = cur_index_reg + 1'b1;
                o_time  = gap_time_reg;
                o_sums  = '0;
                o_marks = '0;
            end
            ROW_REJECT:
            begin
                o_time  = slice_reg;
                o_sums  = '0;
                o_marks = '0;
            end
            default:
            begin
                o_index = cur_index_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slice_length_reg <= LEN_RESET;
            have_row_reg     <= 1'b0;
            cur_slice_reg    <= '0;
            cur_index_reg    <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
                slice_length_reg <= cfg_wr_data;
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (state_reg == ST_UPDATE)
            begin
                have_row_reg <= 1'b1;
                if (!have_row_reg)
                begin
                    cur_slice_reg <= slice_reg;
                    cur_index_reg <= '0;
                end
                else if (gt_reg)
                begin
                    cur_slice_reg <= slice_reg;
                    cur_index_reg <= cur_index_reg + (gap_reg ? IDX_BITS'(2) : IDX_BITS'(1));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg  <= s_tuser;
            time_reg <= s_tdata[TIME_BITS-1:0];
            cls_reg  <= s_tdata[TIME_BITS +: CLS_BITS];
            amt_reg  <= s_tdata[TIME_BITS + CLS_BITS +: AMT_BITS];
            len_reg  <= eff_len;
        end
        if (state_reg == ST_SUB)
            slice_reg <= time_reg - {{(TIME_BITS - LEN_BITS){1'b0}}, rem};
        if (state_reg == ST_DIFF)
        begin
            diff_reg <= diff_full[TIME_BITS-1:0];
            lt_reg   <= diff_full[TIME_BITS];
            gt_reg   <= !diff_full[TIME_BITS] && (diff_full[TIME_BITS-1:0] != '0);
        end
        if (state_reg == ST_GAP)
        begin
            gap_reg      <= (diff_reg > len_ext);
            gap_time_reg <= cur_slice_reg + len_ext;
        end
        if (out_load)
        begin
            m_tdata_reg <= {1'b0, o_marks,
                            o_sums[CLS_MARK], o_sums[CLS_WARNING],
                            o_sums[CLS_ERROR], o_sums[CLS_NORMAL],
                            o_time, o_index};
            m_tuser_reg <= out_kind;
            m_tlast_reg <= out_last;
        end
    end

    assign s_tready = ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `TSB_ASSERT_IMP(a_div_running, clk, rst_n, state_reg == ST_DIV,
                    div_status.busy || div_status.done, "waiting on an idle remainder unit")
    `TSB_ASSERT_IMP(a_ready_div_idle, clk, rst_n, s_tready, !div_status.busy,
                    "input taken while remainder unit busy")
    `TSB_ASSERT_IMP(a_reject_empty, clk, rst_n, m_tvalid_reg && (m_tuser_reg == ROW_REJECT),
                    m_tdata_reg[OUT_DATA_BITS-1:TIME_BITS+IDX_BITS] == '0,
                    "rejected event carries sums")

endmodule
